### design/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared types and constants of the LED frame PWM scanner.
// ----------------------------------------------------------------------------
package lfps_pkg;

  // Chain size and frame store layout (one row of six colour bytes per board)
  localparam int MAX_BOARDS = 128;
  localparam int LANES      = 6;
  localparam int ROW_W      = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;
  localparam int PTR_ROW_W  = $clog2(MAX_BOARDS + 1);
  localparam int LANE_W     = $clog2(LANES);

  // Request kinds
  localparam logic REQ_RX   = 1'b0;
  localparam logic REQ_SCAN = 1'b1;

  // Byte that returns the write pointer to the start
  localparam logic [7:0] RESET_BYTE = 8'h42;

  // Chain length after reset
  localparam logic [7:0] CHAIN_LEN_RESET = 8'd83;

  // Colour masks of one nibble
  localparam logic [3:0] MASK_RED   = 4'hC;
  localparam logic [3:0] MASK_GREEN = 4'h2;
  localparam logic [3:0] MASK_BLUE  = 4'h1;

  // Output bits set by each colour byte of a board; lane 0 is the last entry
  localparam logic [LANES-1:0][7:0] LANE_MASK = {
    {4'h0, MASK_BLUE}, {4'h0, MASK_GREEN}, {4'h0, MASK_RED},
    {MASK_BLUE, 4'h0}, {MASK_GREEN, 4'h0}, {MASK_RED, 4'h0}
  };

  // Dither threshold per PWM phase
  localparam logic [15:0][7:0] DITHER = {
    8'd248, 8'd120, 8'd184, 8'd56, 8'd216, 8'd88, 8'd152, 8'd24,
    8'd232, 8'd104, 8'd168, 8'd40, 8'd200, 8'd72, 8'd136, 8'd8
  };

  // Requests from the scheduler to the frame store
  typedef struct packed {
    logic             wr_en;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
  } store_req_t;

  // Registered read data of one row, with the lanes that were ever written
  typedef struct packed {
    logic [LANES-1:0][7:0] data;
    logic [LANES-1:0]      ok;
  } store_rsp_t;

endpackage

### design/lfps_if.sv
// ----------------------------------------------------------------------------
// lfps_if
// Valid/ready channels of the LED frame PWM scanner.
// ----------------------------------------------------------------------------
interface lfps_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface lfps_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] shift_byte;
  logic       latch;

  modport source (output valid, output shift_byte, output latch, input ready);
  modport sink   (input valid, input shift_byte, input latch, output ready);
endinterface

### design/lfps_ram.sv
// ----------------------------------------------------------------------------
// lfps_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lfps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register read data; hold it while no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/lfps_store.sv
// ----------------------------------------------------------------------------
// lfps_store
// Frame store: six byte lanes, one row per board, fed by a write pointer.
// A fill mark tracks the written prefix so unwritten bytes read as zero.
// ----------------------------------------------------------------------------
module lfps_store (
  input  logic                clk,
  input  logic                rst,
  input  lfps_pkg::store_req_t req,
  output lfps_pkg::store_rsp_t rsp
);

  logic [lfps_pkg::PTR_ROW_W-1:0]   wp_row;
  logic [lfps_pkg::LANE_W-1:0]      wp_lane;
  logic [lfps_pkg::PTR_ROW_W-1:0]   fill_row;
  logic [lfps_pkg::LANE_W-1:0]      fill_lane;
  logic                             store_en;
  logic                             at_fill;
  logic [lfps_pkg::PTR_ROW_W-1:0]   nxt_row;
  logic [lfps_pkg::LANE_W-1:0]      nxt_lane;
  logic [lfps_pkg::PTR_ROW_W-1:0]   rd_row_ext;
  logic [lfps_pkg::LANES-1:0]       ok_next;
  logic [lfps_pkg::LANES-1:0]       ok_q;
  logic [lfps_pkg::LANES-1:0][7:0]  lane_rdata;

  // Store the byte unless it clears the pointer or the store is full
  assign store_en = req.wr_en && (req.wr_data != lfps_pkg::RESET_BYTE) &&
                    (wp_row != lfps_pkg::PTR_ROW_W'(lfps_pkg::MAX_BOARDS));
  assign at_fill  = (wp_row == fill_row) && (wp_lane == fill_lane);

  // Position after the current pointer
  always_comb begin
    if (wp_lane == lfps_pkg::LANE_W'(lfps_pkg::LANES - 1)) begin
      nxt_lane = '0;
      nxt_row  = wp_row + 1'b1;
    end else begin
      nxt_lane = wp_lane + 1'b1;
      nxt_row  = wp_row;
    end
  end

  // Advance the write pointer and the fill mark
  always_ff @(posedge clk) begin
    if (rst) begin
      wp_row    <= '0;
      wp_lane   <= '0;
      fill_row  <= '0;
      fill_lane <= '0;
    end else if (req.wr_en) begin
      if (req.wr_data == lfps_pkg::RESET_BYTE) begin
        wp_row  <= '0;
        wp_lane <= '0;
      end else if (store_en) begin
        wp_row  <= nxt_row;
        wp_lane <= nxt_lane;
        if (at_fill) begin
          fill_row  <= nxt_row;
          fill_lane <= nxt_lane;
        end
      end
    end
  end

  // Lanes of the read row that lie inside the written prefix
  assign rd_row_ext = lfps_pkg::PTR_ROW_W'(req.rd_row);
  always_comb begin
    for (int l = 0; l < lfps_pkg::LANES; l++) begin
      ok_next[l] = (rd_row_ext < fill_row) ||
                   ((rd_row_ext == fill_row) && (lfps_pkg::LANE_W'(l) < fill_lane));
    end
  end

  // Register the written flags alongside the RAM data
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      ok_q <= ok_next;
    end
  end

  assign rsp.data = lane_rdata;
  assign rsp.ok   = ok_q;

  // One RAM per lane
  for (genvar g = 0; g < lfps_pkg::LANES; g++) begin : g_lane
    lfps_ram #(
      .WIDTH (8),
      .DEPTH (lfps_pkg::MAX_BOARDS)
    ) u_ram (
      .clk   (clk),
      .we    (store_en && (wp_lane == lfps_pkg::LANE_W'(g))),
      .waddr (wp_row[lfps_pkg::ROW_W-1:0]),
      .wdata (req.wr_data),
      .re    (req.rd_en),
      .raddr (req.rd_row),
      .rdata (lane_rdata[g])
    );
  end

endmodule

### design/lfps_sched.sv
// ----------------------------------------------------------------------------
// lfps_sched
// Scan sequencer: pass and PWM phase state, store write and read issue,
// threshold compare and the output register.
// ----------------------------------------------------------------------------
module lfps_sched (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           chain_len,
  lfps_req_if.sink             req,
  lfps_res_if.source           res,
  output lfps_pkg::store_req_t store_req,
  input  lfps_pkg::store_rsp_t store_rsp
);

  logic [3:0]                 phase;
  logic [lfps_pkg::ROW_W-1:0] board;
  logic                       pass_active;

  logic                       s1_valid;
  logic [7:0]                 s1_thr;
  logic                       s1_last;

  logic                       out_free;
  logic                       take;
  logic                       scan_fire;
  logic [lfps_pkg::ROW_W-1:0] first_row;
  logic [lfps_pkg::ROW_W-1:0] row;
  logic [3:0]                 phase_use;
  logic [7:0]                 shift_next;
  logic [7:0]                 colour;

  // Accept while the read stage can move on
  assign out_free  = !res.valid || res.ready;
  assign req.ready = !s1_valid || out_free;
  assign take      = req.valid && req.ready;
  assign scan_fire = take && (req.req_type == lfps_pkg::REQ_SCAN);

  // First board of a pass, from the clamped chain length
  always_comb begin
    if (chain_len == 8'd0) begin
      first_row = '0;
    end else if (int'(chain_len) > lfps_pkg::MAX_BOARDS) begin
      first_row = lfps_pkg::ROW_W'(lfps_pkg::MAX_BOARDS - 1);
    end else begin
      first_row = lfps_pkg::ROW_W'(chain_len - 8'd1);
    end
  end

  assign row       = pass_active ? board : first_row;
  assign phase_use = pass_active ? phase : phase + 4'd1;

  // Issue the store access
  always_comb begin
    store_req.wr_en   = take && (req.req_type == lfps_pkg::REQ_RX);
    store_req.wr_data = req.rx_byte;
    store_req.rd_en   = scan_fire;
    store_req.rd_row  = row;
  end

  // Step the pass
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      board       <= '0;
      pass_active <= 1'b0;
    end else if (scan_fire) begin
      phase       <= phase_use;
      board       <= row - 1'b1;
      pass_active <= (row != '0);
    end
  end

  // Read stage: carry threshold and latch alongside the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan_fire) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_fire) begin
      s1_thr  <= lfps_pkg::DITHER[phase_use];
      s1_last <= (row == '0);
    end
  end

  // Compare each colour byte against the threshold
  always_comb begin
    shift_next = '0;
    colour     = '0;
    for (int l = 0; l < lfps_pkg::LANES; l++) begin
      colour = store_rsp.ok[l] ? store_rsp.data[l] : 8'd0;
      if (colour > s1_thr) begin
        shift_next = shift_next | lfps_pkg::LANE_MASK[l];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_free) begin
      res.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      res.shift_byte <= shift_next;
      res.latch      <= s1_last;
    end
  end

endmodule

### design/led_frame_pwm_scanner.sv
// ----------------------------------------------------------------------------
// led_frame_pwm_scanner
// Frame store and PWM scan driver for a chain of LED boards.
// ----------------------------------------------------------------------------
// Received bytes (req_type 0) fill the frame store six colour bytes per board;
// 0x42 returns the write pointer to the start, and bytes beyond the end of the
// store are dropped. Each scan tick (req_type 1) yields one shift byte, from
// the last board down to board 0, where latch is set. The store is six byte
// lanes of one row per board, so a whole board is read in one RAM access:
// with res.ready high one item transfers every cycle. A scan result is
// registered first by the RAM read at its transfer edge and then by the
// output register before it is presented on res. While res.ready is low
// the read stage and the output register hold up to two results; with both
// full, req.ready drops for received bytes and scan ticks alike. No clearing
// pass is needed after reset; a fill mark makes never-written bytes read as
// zero. The chain length is written through cfg_we/cfg_wdata and takes
// effect at the start of the next pass.
module led_frame_pwm_scanner (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  lfps_req_if.sink   req,
  lfps_res_if.source res
);

  logic [7:0]           chain_len;
  lfps_pkg::store_req_t store_req;
  lfps_pkg::store_rsp_t store_rsp;

  // Hold the chain length register
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_len <= lfps_pkg::CHAIN_LEN_RESET;
    end else if (cfg_we) begin
      chain_len <= cfg_wdata;
    end
  end

  lfps_sched u_sched (
    .clk        (clk),
    .rst        (rst),
    .chain_len  (chain_len),
    .req        (req),
    .res        (res),
    .store_req  (store_req),
    .store_rsp  (store_rsp)
  );

  lfps_store u_store (
    .clk (clk),
    .rst (rst),
    .req (store_req),
    .rsp (store_rsp)
  );

endmodule
